// ===== rtl/mds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus data model store package
// Shared widths, operation and register codes, and the store control struct.
// ----------------------------------------------------------------------------
package mds_pkg;

    localparam int OP_W        = 4;
    localparam int FIELD_W     = 16;
    localparam int LIM_W       = 17;
    localparam int ELEM_W      = 20;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_BIT_W = 11;
    localparam int COUNT_REG_W = 9;
    localparam int SRC_W       = 3;

    localparam logic [OP_W-1:0] OP_RD_COILS    = 4'd0;
    localparam logic [OP_W-1:0] OP_RD_DISCRETE = 4'd1;
    localparam logic [OP_W-1:0] OP_RD_HOLDING  = 4'd2;
    localparam logic [OP_W-1:0] OP_RD_INPUTREG = 4'd3;
    localparam logic [OP_W-1:0] OP_WR_COIL     = 4'd4;
    localparam logic [OP_W-1:0] OP_WR_REG      = 4'd5;
    localparam logic [OP_W-1:0] OP_WR_COILS    = 4'd6;
    localparam logic [OP_W-1:0] OP_WR_REGS     = 4'd7;
    localparam logic [OP_W-1:0] OP_SET_DISC    = 4'd8;
    localparam logic [OP_W-1:0] OP_SET_INREG   = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_COIL_COUNT      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCRETE_COUNT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDING_COUNT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_REG_COUNT = 8'd3;

    // Which store supplies the read data of a result.
    localparam logic [SRC_W-1:0] SRC_NONE  = 3'd0;
    localparam logic [SRC_W-1:0] SRC_COIL  = 3'd1;
    localparam logic [SRC_W-1:0] SRC_DISC  = 3'd2;
    localparam logic [SRC_W-1:0] SRC_HOLD  = 3'd3;
    localparam logic [SRC_W-1:0] SRC_INREG = 3'd4;

    typedef struct packed {
        logic clr;
        logic wr;
        logic rd;
    } t_mem_ctl;

endpackage
`default_nettype wire

// ===== rtl/mds_bit_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus bit table
// Eight one-bit banks, interleaved by element address, so that any eight
// adjacent elements are read or written in a single access.
// ----------------------------------------------------------------------------
module mds_bit_store
    import mds_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire t_mem_ctl          i_ctl,
    input  wire logic [LIM_W-1:0]  i_clr_row,
    input  wire logic [ELEM_W-1:0] i_elem,
    input  wire logic [7:0]        i_mask,
    input  wire logic [7:0]        i_wbits,
    output logic [7:0]             o_rbits
);

    localparam int ROWS = (DEPTH + 7) / 8;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int EW   = RW + 3;

    logic [2:0]    lo;
    logic [RW-1:0] hi;
    logic [7:0]    r_rd;
    logic [2:0]    r_lo;
    logic [7:0]    r_mask;

    assign lo = i_elem[2:0];
    assign hi = i_elem[EW-1:3];

    for (genvar j = 0; j < 8; j++) begin : g_bank
        logic          r_mem [ROWS];
        logic [2:0]    off;
        logic [RW-1:0] row;

        // Bank j holds the window bit at offset (j - lo) mod 8; banks below
        // the window's first bank wrap onto the next row.
        assign off = 3'(j) - lo;
        assign row = hi + RW'(3'(j) < lo);

        always_ff @(posedge i_clk) begin
            if (i_ctl.clr) begin
                if (32'(i_clr_row) < ROWS) begin
                    r_mem[i_clr_row[RW-1:0]] <= 1'b0;
                end
            end else if (i_ctl.wr && i_mask[off]) begin
                r_mem[row] <= i_wbits[off];
            end
            if (i_ctl.rd) begin
                r_rd[j] <= r_mem[row];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_lo   <= lo;
            r_mask <= i_mask;
        end
    end

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            o_rbits[b] = r_rd[3'(r_lo + 3'(b))] & r_mask[b];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mds_word_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus register table
// One 16-bit word memory; read and write share one address; registered read.
// ----------------------------------------------------------------------------
module mds_word_store
    import mds_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire t_mem_ctl           i_ctl,
    input  wire logic [LIM_W-1:0]   i_clr_row,
    input  wire logic [LIM_W-1:0]   i_addr,
    input  wire logic [FIELD_W-1:0] i_wdata,
    output logic [FIELD_W-1:0]      o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [FIELD_W-1:0] r_mem [DEPTH];
    logic [FIELD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            if (32'(i_clr_row) < DEPTH) begin
                r_mem[i_clr_row[AW-1:0]] <= '0;
            end
        end else if (i_ctl.wr) begin
            r_mem[i_addr[AW-1:0]] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/modbus_data_model_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus data model store
// Coils, discrete inputs, holding and input registers of a Modbus slave.
// ----------------------------------------------------------------------------
// One request chunk is taken per cycle while o_stall is low; its result
// passes the input register, table access stage and result register before
// it is offered. The single access port of each table sets that pace.
// After reset the tables are zeroed by a pass over max(ceil(COIL_DEPTH/8),
// ceil(DISCRETE_DEPTH/8), HOLDING_DEPTH, INPUT_REG_DEPTH) rows, 256 at the
// defaults, while o_stall stays high; configuration writes are always taken.
module modbus_data_model_store
    import mds_pkg::*;
#(
    parameter int COIL_DEPTH      = 1024,
    parameter int DISCRETE_DEPTH  = 1024,
    parameter int HOLDING_DEPTH   = 256,
    parameter int INPUT_REG_DEPTH = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [FIELD_W-1:0]    i_start_address,
    input  wire logic [FIELD_W-1:0]    i_quantity,
    input  wire logic [FIELD_W-1:0]    i_chunk_index,
    input  wire logic [FIELD_W-1:0]    i_write_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [FIELD_W-1:0]         o_read_data,
    output logic                       o_status,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COIL_ROWS = (COIL_DEPTH + 7) / 8;
    localparam int DISC_ROWS = (DISCRETE_DEPTH + 7) / 8;
    localparam int BIT_ROWS  = (COIL_ROWS > DISC_ROWS) ? COIL_ROWS : DISC_ROWS;
    localparam int WORD_ROWS = (HOLDING_DEPTH > INPUT_REG_DEPTH) ?
                               HOLDING_DEPTH : INPUT_REG_DEPTH;
    localparam int CLR_ROWS  = (BIT_ROWS > WORD_ROWS) ? BIT_ROWS : WORD_ROWS;
    localparam int CW        = (CLR_ROWS > 1) ? $clog2(CLR_ROWS) : 1;

    function automatic logic [LIM_W-1:0] f_sat(input logic [LIM_W-1:0] v,
                                               input logic [LIM_W-1:0] d);
        return (v < d) ? v : d;
    endfunction

    // Table limits, already saturated at the table depth.
    logic [LIM_W-1:0] r_coil_lim;
    logic [LIM_W-1:0] r_disc_lim;
    logic [LIM_W-1:0] r_hold_lim;
    logic [LIM_W-1:0] r_inreg_lim;

    logic          r_clr_busy;
    logic [CW-1:0] r_clr_idx;

    logic               r_a_valid;
    logic [OP_W-1:0]    r_a_op;
    logic [FIELD_W-1:0] r_a_sa;
    logic [FIELD_W-1:0] r_a_q;
    logic [FIELD_W-1:0] r_a_k;
    logic [FIELD_W-1:0] r_a_wd;

    logic             r_b_valid;
    logic             r_b_status;
    logic [SRC_W-1:0] r_b_src;

    logic               r_c_valid;
    logic [FIELD_W-1:0] r_c_data;
    logic               r_c_status;

    logic en_a;
    logic en_b;
    logic en_c;
    logic go;

    logic [LIM_W-1:0]  req_end;
    logic [LIM_W-1:0]  reg_addr;
    logic [ELEM_W-1:0] chunk_elem;
    logic [7:0]        chunk_mask;
    logic              k_in;

    logic               n_err;
    logic [SRC_W-1:0]   n_src;
    logic [ELEM_W-1:0]  bit_elem;
    logic [7:0]         bit_mask;
    logic [7:0]         bit_wbits;
    logic [LIM_W-1:0]   word_addr;
    t_mem_ctl           coil_ctl;
    t_mem_ctl           disc_ctl;
    t_mem_ctl           hold_ctl;
    t_mem_ctl           inreg_ctl;
    logic [LIM_W-1:0]   clr_row;
    logic [7:0]         coil_rbits;
    logic [7:0]         disc_rbits;
    logic [FIELD_W-1:0] hold_rdata;
    logic [FIELD_W-1:0] inreg_rdata;
    logic [FIELD_W-1:0] n_c_data;

    // A stage moves on when the one after it is empty or moving on.
    assign en_c    = !r_c_valid || !i_stall;
    assign en_b    = !r_b_valid || en_c;
    assign en_a    = !r_a_valid || en_b;
    assign go      = r_a_valid && en_b;
    assign o_stall = r_clr_busy || !en_a;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coil_lim  <= LIM_W'(COIL_DEPTH);
            r_disc_lim  <= LIM_W'(DISCRETE_DEPTH);
            r_hold_lim  <= LIM_W'(HOLDING_DEPTH);
            r_inreg_lim <= LIM_W'(INPUT_REG_DEPTH);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COIL_COUNT: begin
                    r_coil_lim <= f_sat(LIM_W'(i_cfg_data[COUNT_BIT_W-1:0]),
                                        LIM_W'(COIL_DEPTH));
                end
                CFG_DISCRETE_COUNT: begin
                    r_disc_lim <= f_sat(LIM_W'(i_cfg_data[COUNT_BIT_W-1:0]),
                                        LIM_W'(DISCRETE_DEPTH));
                end
                CFG_HOLDING_COUNT: begin
                    r_hold_lim <= f_sat(LIM_W'(i_cfg_data[COUNT_REG_W-1:0]),
                                        LIM_W'(HOLDING_DEPTH));
                end
                CFG_INPUT_REG_COUNT: begin
                    r_inreg_lim <= f_sat(LIM_W'(i_cfg_data[COUNT_REG_W-1:0]),
                                         LIM_W'(INPUT_REG_DEPTH));
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == CW'(CLR_ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    assign clr_row = LIM_W'(r_clr_idx);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_valid && !r_clr_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_op <= i_operation;
            r_a_sa <= i_start_address;
            r_a_q  <= i_quantity;
            r_a_k  <= i_chunk_index;
            r_a_wd <= i_write_data;
        end
    end

    assign req_end    = {1'b0, r_a_sa} + {1'b0, r_a_q};
    assign reg_addr   = {1'b0, r_a_sa} + {1'b0, r_a_k};
    assign chunk_elem = {4'b0, r_a_sa} + {1'b0, r_a_k, 3'b000};
    assign k_in       = r_a_k < r_a_q;

    // Bit b of a packed chunk is element 8*k+b of the request.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            chunk_mask[b] = ({1'b0, r_a_k, 3'b000} + ELEM_W'(b)) < {4'b0, r_a_q};
        end
    end

    always_comb begin
        n_err     = 1'b0;
        n_src     = SRC_NONE;
        bit_elem  = chunk_elem;
        bit_mask  = chunk_mask;
        bit_wbits = r_a_wd[7:0];
        word_addr = reg_addr;
        coil_ctl  = '0;
        disc_ctl  = '0;
        hold_ctl  = '0;
        inreg_ctl = '0;
        unique case (r_a_op)
            OP_RD_COILS: begin
                n_err       = req_end > r_coil_lim;
                n_src       = SRC_COIL;
                coil_ctl.rd = go && !n_err;
            end
            OP_RD_DISCRETE: begin
                n_err       = req_end > r_disc_lim;
                n_src       = SRC_DISC;
                disc_ctl.rd = go && !n_err;
            end
            OP_RD_HOLDING: begin
                n_err       = req_end > r_hold_lim;
                n_src       = k_in ? SRC_HOLD : SRC_NONE;
                hold_ctl.rd = go && !n_err && k_in;
            end
            OP_RD_INPUTREG: begin
                n_err        = req_end > r_inreg_lim;
                n_src        = k_in ? SRC_INREG : SRC_NONE;
                inreg_ctl.rd = go && !n_err && k_in;
            end
            OP_WR_COIL: begin
                n_err       = {1'b0, r_a_sa} >= r_coil_lim;
                bit_elem    = ELEM_W'(r_a_sa);
                bit_mask    = 8'h01;
                bit_wbits   = {7'b0, |r_a_wd};
                coil_ctl.wr = go && !n_err;
            end
            OP_WR_REG: begin
                n_err       = {1'b0, r_a_sa} >= r_hold_lim;
                word_addr   = {1'b0, r_a_sa};
                hold_ctl.wr = go && !n_err;
            end
            OP_WR_COILS: begin
                n_err       = req_end > r_coil_lim;
                coil_ctl.wr = go && !n_err;
            end
            OP_WR_REGS: begin
                n_err       = req_end > r_hold_lim;
                hold_ctl.wr = go && !n_err && k_in;
            end
            OP_SET_DISC: begin
                n_err       = {1'b0, r_a_sa} >= r_disc_lim;
                bit_elem    = ELEM_W'(r_a_sa);
                bit_mask    = 8'h01;
                bit_wbits   = {7'b0, |r_a_wd};
                disc_ctl.wr = go && !n_err;
            end
            OP_SET_INREG: begin
                n_err        = {1'b0, r_a_sa} >= r_inreg_lim;
                word_addr    = {1'b0, r_a_sa};
                inreg_ctl.wr = go && !n_err;
            end
            default: begin
            end
        endcase
        coil_ctl.clr  = r_clr_busy;
        disc_ctl.clr  = r_clr_busy;
        hold_ctl.clr  = r_clr_busy;
        inreg_ctl.clr = r_clr_busy;
    end

    mds_bit_store #(
        .DEPTH (COIL_DEPTH)
    ) u_coil (
        .i_clk     (i_clk),
        .i_ctl     (coil_ctl),
        .i_clr_row (clr_row),
        .i_elem    (bit_elem),
        .i_mask    (bit_mask),
        .i_wbits   (bit_wbits),
        .o_rbits   (coil_rbits)
    );

    mds_bit_store #(
        .DEPTH (DISCRETE_DEPTH)
    ) u_disc (
        .i_clk     (i_clk),
        .i_ctl     (disc_ctl),
        .i_clr_row (clr_row),
        .i_elem    (bit_elem),
        .i_mask    (bit_mask),
        .i_wbits   (bit_wbits),
        .o_rbits   (disc_rbits)
    );

    mds_word_store #(
        .DEPTH (HOLDING_DEPTH)
    ) u_hold (
        .i_clk     (i_clk),
        .i_ctl     (hold_ctl),
        .i_clr_row (clr_row),
        .i_addr    (word_addr),
        .i_wdata   (r_a_wd),
        .o_rdata   (hold_rdata)
    );

    mds_word_store #(
        .DEPTH (INPUT_REG_DEPTH)
    ) u_inreg (
        .i_clk     (i_clk),
        .i_ctl     (inreg_ctl),
        .i_clr_row (clr_row),
        .i_addr    (word_addr),
        .i_wdata   (r_a_wd),
        .o_rdata   (inreg_rdata)
    );

    // Table access stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_status <= n_err;
            r_b_src    <= n_err ? SRC_NONE : n_src;
        end
    end

    always_comb begin
        case (r_b_src)
            SRC_COIL:  n_c_data = {8'b0, coil_rbits};
            SRC_DISC:  n_c_data = {8'b0, disc_rbits};
            SRC_HOLD:  n_c_data = hold_rdata;
            SRC_INREG: n_c_data = inreg_rdata;
            default:   n_c_data = '0;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_data   <= n_c_data;
            r_c_status <= r_b_status;
        end
    end

    assign o_valid     = r_c_valid;
    assign o_read_data = r_c_data;
    assign o_status    = r_c_status;

    a_err_no_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_read_data == '0)
        else $error("error result carries read data");

    a_clear_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> !r_a_valid && !r_b_valid && !r_c_valid)
        else $error("item entered during table clearing");

    a_a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !en_b |=> r_a_valid && $stable(r_a_op) && $stable(r_a_sa)
                               && $stable(r_a_k))
        else $error("blocked input stage item was overwritten");

endmodule
`default_nettype wire
